/* sv/stwd_pkg.sv */
package stwd_pkg;

  // Counter width for half period, tone and duration counts
  localparam int CounterBits = 16;

  // Field widths
  localparam int ClockHzWidth  = 24;
  localparam int TicksWidth    = 16;
  localparam int DurationWidth = 16;
  localparam int FreqWidth     = 15;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = ClockHzWidth;

  // Shared unit widths: divisor is 4 * freq, product is ms * ticks
  localparam int DivisorWidth = FreqWidth + 2;
  localparam int WordWidth    = 32;
  localparam int DivSteps     = ClockHzWidth;
  localparam int MulSteps     = DurationWidth;
  localparam int StepBits     = $clog2(DivSteps);

  // Register reset values
  localparam logic [ClockHzWidth-1:0]  ClockHzReset     = 24'd750000;
  localparam logic [TicksWidth-1:0]    TicksPerMsReset  = 16'd375;
  localparam logic [DurationWidth-1:0] MaxDurationReset = 16'd174;
  localparam logic [FreqWidth-1:0]     MinFreqReset     = 15'd3;
  localparam logic [FreqWidth-1:0]     MaxFreqReset     = 15'd20000;

  // Register indexes
  localparam logic [CfgIndexWidth-1:0] CfgClockHz     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgTicksPerMs  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgMaxDuration = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgMinFreq     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgMaxFreq     = 3'd4;

  // Item modes
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeQuiet = 2'd2;

  typedef enum logic {
    OpDiv,
    OpMul
  } arith_op_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StMul,
    StFin
  } state_e;

  typedef struct packed {
    logic                     [1:0] mode;
    logic signed              [15:0] tone_freq;
    logic [DurationWidth-1:0] duration_ms;
  } in_item_t;

  typedef struct packed {
    logic speaker_level;
    logic tone_active;
    logic duration_running;
    logic request_rejected;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    arith_op_e               op;
    logic [WordWidth-1:0]    operand_a;
    logic [DivisorWidth-1:0] operand_b;
  } arith_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [WordWidth-1:0] result;
  } arith_rsp_t;

endpackage

/* sv/stwd_arith.sv */
module stwd_arith (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stwd_pkg::arith_cmd_t cmd_i,
  output stwd_pkg::arith_rsp_t rsp_o
);

  localparam int WW = stwd_pkg::WordWidth;
  localparam int DW = stwd_pkg::DivisorWidth;
  localparam int CW = stwd_pkg::ClockHzWidth;
  localparam int MW = stwd_pkg::MulSteps;
  localparam int SB = stwd_pkg::StepBits;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  stwd_pkg::arith_op_e op_q, op_d;
  logic [SB-1:0]       cnt_q, cnt_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [WW-1:0]       work_q, work_d;
  logic [DW-1:0]       opb_q, opb_d;
  logic [WW-1:0]       acc_q, acc_d;

  logic [WW-1:0]       add_a, add_b;
  logic                add_sub;
  logic [WW:0]         sum;
  logic                no_borrow;

  // Shared adder: trial subtract for divide, shift-add for multiply
  always_comb begin
    if (op_q == stwd_pkg::OpDiv) begin
      add_a   = {{(WW-DW-1){1'b0}}, rem_q, work_q[CW-1]};
      add_b   = {{(WW-DW){1'b0}}, opb_q};
      add_sub = 1'b1;
    end else begin
      add_a   = {acc_q[WW-2:0], 1'b0};
      add_b   = work_q[MW-1] ? {{(WW-DW){1'b0}}, opb_q} : '0;
      add_sub = 1'b0;
    end
    sum       = {1'b0, add_a} + {1'b0, add_b ^ {WW{add_sub}}} + {{WW{1'b0}}, add_sub};
    no_borrow = sum[WW];
  end

  // Step sequencing
  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    work_d = work_q;
    opb_d  = opb_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      cnt_d  = (cmd_i.op == stwd_pkg::OpDiv) ? SB'(stwd_pkg::DivSteps - 1) : SB'(MW - 1);
      rem_d  = '0;
      work_d = cmd_i.operand_a;
      opb_d  = cmd_i.operand_b;
      acc_d  = '0;
    end else if (busy_q) begin
      if (op_q == stwd_pkg::OpDiv) begin
        rem_d  = no_borrow ? sum[DW-1:0] : {rem_q[DW-2:0], work_q[CW-1]};
        work_d = {work_q[WW-2:0], no_borrow};
      end else begin
        acc_d  = sum[WW-1:0];
        work_d = {work_q[WW-2:0], 1'b0};
      end
      cnt_d = cnt_q - SB'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= stwd_pkg::OpDiv;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    opb_q  <= opb_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == stwd_pkg::OpDiv) ? {{(WW-CW){1'b0}}, work_q[CW-1:0]} : acc_q;

endmodule

/* sv/square_wave_tone_with_duration_core.sv */
// Square wave tone generator with a millisecond duration one-shot. Every input
// item gives exactly one status result. Tick, quiet, unused-mode and rejected
// start items are answered straight from the idle state. An accepted start
// holds the input through accept, 24 divide steps for clock_hz / (4 * freq),
// the quotient hand-over, 16 multiply steps for duration_ms * ticks_per_ms,
// the product hand-over (all through the single shared adder in stwd_arith)
// and the counter load and result post. The input stalls while a start is in
// progress and while a finished result is not yet taken. The user must write
// the configuration registers through cfg_we_i only while the block is idle;
// the block does not enforce this. They take effect on the next start.
module square_wave_tone_with_duration_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [stwd_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [stwd_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  stwd_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output stwd_pkg::out_item_t                   out_data_o
);

  localparam int CB = stwd_pkg::CounterBits;
  localparam int DW = stwd_pkg::DurationWidth;
  localparam int FW = stwd_pkg::FreqWidth;
  localparam int WW = stwd_pkg::WordWidth;
  localparam int CW = stwd_pkg::ClockHzWidth;

  // Configuration registers
  logic [CW-1:0]                   clock_hz_q;
  logic [stwd_pkg::TicksWidth-1:0] ticks_per_ms_q;
  logic [DW-1:0]                   max_duration_q;
  logic [FW-1:0]                   min_freq_q;
  logic [FW-1:0]                   max_freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q     <= stwd_pkg::ClockHzReset;
      ticks_per_ms_q <= stwd_pkg::TicksPerMsReset;
      max_duration_q <= stwd_pkg::MaxDurationReset;
      min_freq_q     <= stwd_pkg::MinFreqReset;
      max_freq_q     <= stwd_pkg::MaxFreqReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        stwd_pkg::CfgClockHz:     clock_hz_q     <= cfg_wdata_i[CW-1:0];
        stwd_pkg::CfgTicksPerMs:  ticks_per_ms_q <= cfg_wdata_i[stwd_pkg::TicksWidth-1:0];
        stwd_pkg::CfgMaxDuration: max_duration_q <= cfg_wdata_i[DW-1:0];
        stwd_pkg::CfgMinFreq:     min_freq_q     <= cfg_wdata_i[FW-1:0];
        stwd_pkg::CfgMaxFreq:     max_freq_q     <= cfg_wdata_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // Tone state
  stwd_pkg::state_e    state_q, state_d;
  logic [CB-1:0]       half_period_q, half_period_d;
  logic [CB-1:0]       tone_count_q, tone_count_d;
  logic [CB-1:0]       dur_count_q, dur_count_d;
  logic                wave_q, wave_d;
  logic                tone_on_q, tone_on_d;
  logic                dur_on_q, dur_on_d;
  logic [CB-1:0]       hp_new_q, hp_new_d;
  logic [DW-1:0]       ms_q, ms_d;
  logic                out_valid_q, out_valid_d;
  stwd_pkg::out_item_t out_q, out_d;

  stwd_pkg::arith_cmd_t arith_cmd;
  stwd_pkg::arith_rsp_t arith_rsp;

  logic          in_xfer;
  logic          out_free;
  logic          freq_pos;
  logic          reject;
  logic [DW-1:0] ms_clamped;
  logic [CB-1:0] hp_sat;
  logic [CB-1:0] dc_sat;
  logic          load_out;
  logic          rej_flag;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_xfer  = in_valid_i && !in_stall_o;

  // Start checks and clamps
  always_comb begin
    freq_pos   = !in_data_i.tone_freq[15] && (in_data_i.tone_freq != '0);
    reject     = !freq_pos || (in_data_i.tone_freq[FW-1:0] < min_freq_q) ||
                 (in_data_i.tone_freq[FW-1:0] > max_freq_q) || (in_data_i.duration_ms == '0);
    ms_clamped = (in_data_i.duration_ms > max_duration_q) ? max_duration_q
                                                          : in_data_i.duration_ms;
  end

  // Saturate quotient and product to the counter width; a zero quotient becomes 1
  always_comb begin
    if (arith_rsp.result[WW-1:CB] != '0) begin
      hp_sat = '1;
    end else if (arith_rsp.result[CB-1:0] == '0) begin
      hp_sat = CB'(1);
    end else begin
      hp_sat = arith_rsp.result[CB-1:0];
    end
    dc_sat = (arith_rsp.result[WW-1:CB] != '0) ? '1 : arith_rsp.result[CB-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stwd_pkg::StIdle: begin
        if (in_xfer && (in_data_i.mode == stwd_pkg::ModeStart) && !reject) begin
          state_d = stwd_pkg::StDiv;
        end
      end
      stwd_pkg::StDiv: begin
        if (arith_rsp.done) state_d = stwd_pkg::StMul;
      end
      stwd_pkg::StMul: begin
        if (arith_rsp.done) state_d = stwd_pkg::StFin;
      end
      stwd_pkg::StFin: begin
        if (out_free) state_d = stwd_pkg::StIdle;
      end
      default: state_d = stwd_pkg::StIdle;
    endcase
  end

  // Sequencer outputs: input stall and shared unit commands
  always_comb begin
    in_stall_o          = (state_q != stwd_pkg::StIdle) || !out_free;
    arith_cmd.start     = 1'b0;
    arith_cmd.op        = stwd_pkg::OpDiv;
    arith_cmd.operand_a = {{(WW-CW){1'b0}}, clock_hz_q};
    arith_cmd.operand_b = {in_data_i.tone_freq[FW-1:0], 2'b00};
    case (state_q)
      stwd_pkg::StIdle: begin
        arith_cmd.start = in_xfer && (in_data_i.mode == stwd_pkg::ModeStart) && !reject;
      end
      stwd_pkg::StDiv: begin
        arith_cmd.start     = arith_rsp.done;
        arith_cmd.op        = stwd_pkg::OpMul;
        arith_cmd.operand_a = {{(WW-DW){1'b0}}, ms_q};
        arith_cmd.operand_b = {1'b0, ticks_per_ms_q};
      end
      default: ;
    endcase
  end

  // Tone datapath and result
  always_comb begin
    half_period_d = half_period_q;
    tone_count_d  = tone_count_q;
    dur_count_d   = dur_count_q;
    wave_d        = wave_q;
    tone_on_d     = tone_on_q;
    dur_on_d      = dur_on_q;
    hp_new_d      = hp_new_q;
    ms_d          = ms_q;
    load_out      = 1'b0;
    rej_flag      = 1'b0;
    case (state_q)
      stwd_pkg::StIdle: begin
        if (in_xfer) begin
          case (in_data_i.mode)
            stwd_pkg::ModeTick: begin
              load_out = 1'b1;
              if (tone_on_q) begin
                if (tone_count_q > CB'(1)) begin
                  tone_count_d = tone_count_q - CB'(1);
                end else begin
                  wave_d       = !wave_q;
                  tone_count_d = half_period_q;
                end
              end
              if (dur_on_q) begin
                if (dur_count_q > CB'(1)) begin
                  dur_count_d = dur_count_q - CB'(1);
                end else begin
                  dur_count_d = '0;
                  dur_on_d    = 1'b0;
                end
              end
            end
            stwd_pkg::ModeStart: begin
              if (reject) begin
                load_out = 1'b1;
                rej_flag = 1'b1;
              end else begin
                ms_d = ms_clamped;
              end
            end
            stwd_pkg::ModeQuiet: begin
              load_out      = 1'b1;
              half_period_d = '0;
              tone_count_d  = '0;
              dur_count_d   = '0;
              wave_d        = 1'b0;
              tone_on_d     = 1'b0;
              dur_on_d      = 1'b0;
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      stwd_pkg::StDiv: begin
        if (arith_rsp.done) hp_new_d = hp_sat;
      end
      stwd_pkg::StFin: begin
        if (out_free) begin
          load_out      = 1'b1;
          half_period_d = hp_new_q;
          tone_count_d  = hp_new_q;
          wave_d        = 1'b0;
          tone_on_d     = 1'b1;
          dur_count_d   = dc_sat;
          dur_on_d      = (dc_sat != '0);
        end
      end
      default: ;
    endcase

    out_d = out_q;
    if (load_out) begin
      out_d.speaker_level    = wave_d & tone_on_d;
      out_d.tone_active      = tone_on_d;
      out_d.duration_running = dur_on_d;
      out_d.request_rejected = rej_flag;
    end

    // Output register holds until the transfer completes
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= stwd_pkg::StIdle;
      half_period_q <= '0;
      tone_count_q  <= '0;
      dur_count_q   <= '0;
      wave_q        <= 1'b0;
      tone_on_q     <= 1'b0;
      dur_on_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      half_period_q <= half_period_d;
      tone_count_q  <= tone_count_d;
      dur_count_q   <= dur_count_d;
      wave_q        <= wave_d;
      tone_on_q     <= tone_on_d;
      dur_on_q      <= dur_on_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hp_new_q <= hp_new_d;
    ms_q     <= ms_d;
    out_q    <= out_d;
  end

  stwd_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (arith_cmd),
    .rsp_o  (arith_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import stwd_pkg::*;

  // Mode 3 has no name in the package: it must leave everything alone
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam int DirCount       = 25;
  localparam int NumPhases      = 8;
  localparam int ItemsPerPhase  = 90;
  localparam int HoldOffCycles  = 300;
  // wait after the last expected status before touching registers
  localparam int SettleCycles   = 50;
  localparam int DrainCycles    = 60;
  localparam int WatchdogLimit  = 3000;
  localparam longint unsigned CountMax = (64'd1 << CounterBits) - 1;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  in_item_t                 in_data_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  out_item_t                out_data_o;

  square_wave_tone_with_duration_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Predictor copy of the registers
  logic [ClockHzWidth-1:0]  cfg_clock_hz;
  logic [TicksWidth-1:0]    cfg_ticks_per_ms;
  logic [DurationWidth-1:0] cfg_max_duration;
  logic [FreqWidth-1:0]     cfg_min_freq;
  logic [FreqWidth-1:0]     cfg_max_freq;

  // Predictor copy of the tone state
  logic [CounterBits-1:0] tone_half_period;
  logic [CounterBits-1:0] tone_cnt;
  logic [CounterBits-1:0] dur_cnt;
  logic                   wave_lvl;
  logic                   tone_run;
  logic                   dur_run;

  out_item_t expected_status_q[$];
  int        mismatches = 0;
  bit        hold_off_req = 1'b0;
  int        burst_left = 0;

  // Directed table: item, whether the status is typed in, typed status
  // (status bits: speaker, tone active, duration running, rejected)
  typedef struct packed {
    in_item_t  item;
    logic      status_known;
    out_item_t status;
  } dir_row_t;

  dir_row_t dir_rows [DirCount] = '{
    {ModeTick,   16'd0,     16'd0,     1'b1, 4'b0000},  // tick right after reset
    {ModeUnused, 16'hFFFF,  16'hFFFF,  1'b1, 4'b0000},  // unused mode
    {ModeStart,  16'd0,     16'd10,    1'b1, 4'b0001},  // zero frequency
    {ModeStart,  16'h8000,  16'd10,    1'b1, 4'b0001},  // most negative frequency
    {ModeStart,  16'hFFFF,  16'hFFFF,  1'b1, 4'b0001},  // -1 Hz
    {ModeStart,  16'd2,     16'd10,    1'b1, 4'b0001},  // just below min_freq
    {ModeStart,  16'd20001, 16'd10,    1'b1, 4'b0001},  // just above max_freq
    {ModeStart,  16'h7FFF,  16'd10,    1'b1, 4'b0001},  // largest positive frequency
    {ModeStart,  16'd1000,  16'd0,     1'b1, 4'b0001},  // zero duration
    {ModeQuiet,  16'd0,     16'd0,     1'b1, 4'b0000},  // quiet while idle
    {ModeStart,  16'd3,     16'd1,     1'b1, 4'b0110},  // lowest frequency, 1 ms
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeStart,  16'd20000, 16'hFFFF,  1'b1, 4'b0110},  // retune, duration clamped
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b0, 4'b0000},  // half period reached
    {ModeStart,  16'd12500, 16'd1,     1'b0, 4'b0000},  // retune while high
    {ModeQuiet,  16'd0,     16'd0,     1'b1, 4'b0000},
    {ModeTick,   16'd0,     16'd0,     1'b1, 4'b0000}   // tick after quiet
  };

  function automatic logic [CounterBits-1:0] clamp_count(longint unsigned v);
    return (v > CountMax) ? CountMax[CounterBits-1:0] : v[CounterBits-1:0];
  endfunction

  // Advance the tone state by one item and return the status it reports
  function automatic out_item_t next_tone_status(in_item_t item);
    out_item_t       status;
    int              freq;
    longint unsigned ms_eff;
    longint unsigned quotient;
    status = '0;
    case (item.mode)
      ModeTick: begin
        if (tone_run) begin
          if (tone_cnt > 1) begin
            tone_cnt = tone_cnt - 1'b1;
          end else begin
            wave_lvl = ~wave_lvl;
            tone_cnt = tone_half_period;
          end
        end
        if (dur_run) begin
          if (dur_cnt > 1) begin
            dur_cnt = dur_cnt - 1'b1;
          end else begin
            dur_cnt = '0;
            dur_run = 1'b0;
          end
        end
      end
      ModeStart: begin
        freq   = $signed(item.tone_freq);
        ms_eff = item.duration_ms;
        if (freq < 1 || freq < int'(cfg_min_freq) || freq > int'(cfg_max_freq) ||
            ms_eff == 0) begin
          status.request_rejected = 1'b1;
        end else begin
          if (ms_eff > cfg_max_duration) ms_eff = cfg_max_duration;
          quotient = 64'(cfg_clock_hz) / (64'd4 * 64'(freq));
          // slow clock: toggle on every tick rather than never
          if (quotient == 0) quotient = 1;
          tone_half_period = clamp_count(quotient);
          tone_cnt         = tone_half_period;
          wave_lvl         = 1'b0;
          tone_run         = 1'b1;
          dur_cnt          = clamp_count(ms_eff * cfg_ticks_per_ms);
          dur_run          = (dur_cnt != 0);
        end
      end
      ModeQuiet: begin
        tone_half_period = '0;
        tone_cnt         = '0;
        dur_cnt          = '0;
        wave_lvl         = 1'b0;
        tone_run         = 1'b0;
        dur_run          = 1'b0;
      end
      default: ;
    endcase
    status.speaker_level    = wave_lvl & tone_run;
    status.tone_active      = tone_run;
    status.duration_running = dur_run;
    return status;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  // Offer one item in bursts; queue its status once the transfer happens
  task automatic send_item(in_item_t item, logic status_known, out_item_t status);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (status_known) begin
      void'(next_tone_status(item));
      expected_status_q.push_back(status);
    end else begin
      expected_status_q.push_back(next_tone_status(item));
    end
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgClockHz:     cfg_clock_hz     = data[ClockHzWidth-1:0];
      CfgTicksPerMs:  cfg_ticks_per_ms = data[TicksWidth-1:0];
      CfgMaxDuration: cfg_max_duration = data[DurationWidth-1:0];
      CfgMinFreq:     cfg_min_freq     = data[FreqWidth-1:0];
      CfgMaxFreq:     cfg_max_freq     = data[FreqWidth-1:0];
      default: ;
    endcase
  endtask

  // Drain the block, then load all five registers
  task automatic program_regs(int unsigned clock_hz, int unsigned ticks,
                              int unsigned max_dur, int unsigned min_f,
                              int unsigned max_f);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CfgClockHz, CfgDataWidth'(clock_hz));
    write_reg(CfgTicksPerMs, CfgDataWidth'(ticks));
    write_reg(CfgMaxDuration, CfgDataWidth'(max_dur));
    write_reg(CfgMinFreq, CfgDataWidth'(min_f));
    write_reg(CfgMaxFreq, CfgDataWidth'(max_f));
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus
  initial begin
    in_item_t    item;
    int unsigned sel;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;

    cfg_clock_hz     = ClockHzReset;
    cfg_ticks_per_ms = TicksPerMsReset;
    cfg_max_duration = MaxDurationReset;
    cfg_min_freq     = MinFreqReset;
    cfg_max_freq     = MaxFreqReset;
    tone_half_period = '0;
    tone_cnt         = '0;
    dur_cnt          = '0;
    wave_lvl         = 1'b0;
    tone_run         = 1'b0;
    dur_run          = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under reset register values
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].status_known, dir_rows[i].status);
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        // slowest clock: half period forced to 1, 1-tick durations
        0: program_regs(1, 1, 1, 1, 32767);
        // largest values: both counts can saturate
        1: program_regs(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1, 32767);
        // max duration 0: one-shot never starts
        2: program_regs($urandom_range(100, 4000), $urandom_range(1, 4), 0, 1,
                        $urandom_range(50, 200));
        3: program_regs($urandom_range(200, 5000), $urandom_range(1, 10),
                        $urandom_range(1, 8), $urandom_range(1, 20),
                        $urandom_range(20, 300));
        // only the top frequency passes
        4: program_regs($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 6),
                        $urandom_range(1, 6), 32767, 32767);
        5: program_regs($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 16'hFFFF),
                        $urandom_range(1, 16'hFFFF), $urandom_range(1, 32767),
                        $urandom_range(1, 32767));
        6: program_regs(ClockHzReset, TicksPerMsReset, MaxDurationReset,
                        MinFreqReset, MaxFreqReset);
        default: program_regs($urandom_range(500, 3000), $urandom_range(1, 3),
                              $urandom_range(1, 5), $urandom_range(1, 10),
                              $urandom_range(10, 100));
      endcase
      if (p == 3) hold_off_req = 1'b1;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        sel  = $urandom_range(99);
        item = '0;
        if (sel < 62) begin
          item.mode = ModeTick;
        end else if (sel < 84) begin
          item.mode = ModeStart;
        end else if (sel < 92) begin
          item.mode = ModeQuiet;
        end else begin
          item.mode = ModeUnused;
        end
        // freq: mostly legal, some just outside the window, some anything
        sel = $urandom_range(99);
        if (sel < 70) begin
          item.tone_freq = 16'($urandom_range(cfg_min_freq, cfg_max_freq));
        end else if (sel < 80) begin
          item.tone_freq = ($urandom_range(1)) ? 16'(cfg_min_freq - 1) : 16'(cfg_max_freq + 1);
        end else begin
          item.tone_freq = 16'($urandom);
        end
        sel = $urandom_range(99);
        if (sel < 60) begin
          item.duration_ms = 16'($urandom_range(1, 4));
        end else if (sel < 75) begin
          item.duration_ms = 16'($urandom_range(1, cfg_max_duration + 2));
        end else if (sel < 85) begin
          item.duration_ms = '0;
        end else begin
          item.duration_ms = 16'($urandom);
        end
        send_item(item, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned stretch_left;
    int unsigned stall_pct;
    stretch_left = 0;
    stall_pct    = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(5, 60);
          case ($urandom_range(4))
            0, 1: stall_pct = 0;
            2:    stall_pct = 30;
            3:    stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        stretch_left--;
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result check against the oldest expected status
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("status transfer with nothing expected");
      end else begin
        want = expected_status_q.pop_front();
        if (out_data_o.speaker_level !== want.speaker_level)
          report_mismatch($sformatf("status speaker_level mismatch: got %0b, want %0b",
                                    out_data_o.speaker_level, want.speaker_level));
        if (out_data_o.tone_active !== want.tone_active)
          report_mismatch($sformatf("status tone_active mismatch: got %0b, want %0b",
                                    out_data_o.tone_active, want.tone_active));
        if (out_data_o.duration_running !== want.duration_running)
          report_mismatch($sformatf("status duration_running mismatch: got %0b, want %0b",
                                    out_data_o.duration_running, want.duration_running));
        if (out_data_o.request_rejected !== want.request_rejected)
          report_mismatch($sformatf("status request_rejected mismatch: got %0b, want %0b",
                                    out_data_o.request_rejected, want.request_rejected));
      end
    end
  end

  // Watchdog on cycles without any transfer or register write
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* square_wave_tone_with_duration_core.f */
sv/stwd_pkg.sv
sv/stwd_arith.sv
sv/square_wave_tone_with_duration_core.sv
dv/testbench.sv
